### design/assert_macros.svh
// assertion macros shared by the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check with async reset
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// concurrent check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/fupt_pkg.sv
// ---------------------------------------------------------------------------
// fupt_pkg
// types and constants for the pin table with expiry
// ---------------------------------------------------------------------------
`default_nettype none
package fupt_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = 9;

  typedef enum logic [2:0] {
    OP_VERIFY = 3'd0,
    OP_PIN    = 3'd1,
    OP_REVOKE = 3'd2,
    OP_PRUNE  = 3'd3,
    OP_LOOKUP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_MATCH    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_OK       = 3'd4,
    ST_FULL     = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] host_key;
    logic [15:0] port;
    logic [63:0] fp_digest;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  pruned_count;
    logic [8:0]  live_count;
    logic [63:0] found_fp;
    logic [47:0] found_first_seen;
    logic [48:0] found_expiry;
  } rsp_t;

  typedef struct packed {
    logic [63:0] host;
    logic [15:0] port;
    logic [63:0] fp;
    logic [47:0] first_seen;
    logic [48:0] expiry;
  } entry_t;
endpackage
`default_nettype wire

### design/fupt_ram.sv
// ---------------------------------------------------------------------------
// fupt_ram
// single port entry memory, registered read
// ---------------------------------------------------------------------------
`default_nettype none
module fupt_ram import fupt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] addr_i,
  input  wire entry_t          wdata_i,
  output      entry_t          rdata_o
);
  entry_t mem [TableEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### design/first_use_pin_table_with_expiry.sv
// ---------------------------------------------------------------------------
// first_use_pin_table_with_expiry
// trust on first use pin table keyed by host digest and port
// ---------------------------------------------------------------------------
// usage: drive req_i and raise start while busy is low; the word is taken at
// that edge and busy rises. each command scans the entry memory one address
// per cycle through the single memory port (registered read), then passes
// through a write-back state and a state that forms the result, which is
// registered onto rsp_o with done_o high for exactly one cycle. the receiver
// cannot stall, and busy falls together with done_o, so a new word is only
// taken once the last one is done. valid marks are flip-flops cleared by the
// asynchronous reset rst_ni, used count resets to zero and the lifetime
// register to zero; entry memory needs no clearing. cfg_we_i writes the pin
// lifetime; the user must keep it to any cycle the block is idle, as the
// block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none
module first_use_pin_table_with_expiry import fupt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire req_t        req_i,
  output      logic        done_o,
  output      rsp_t        rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [31:0]       life_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0]   used_q;
  logic [IdxW:0]     addr_q;
  logic [IdxW-1:0]   ridx_q;
  logic              rvalid_q;
  logic              hit_q, free_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;
  entry_t            hit_ent_q;
  logic [CntW-1:0]   pruned_q;
  rsp_t              rsp_q, rsp_d;
  logic              done_q;

  logic              we;
  logic [IdxW-1:0]   maddr;
  entry_t            wdata, rdata;
  logic              rd_valid, rd_match, rd_exp, hit_exp;
  logic [48:0]       new_exp;

  fupt_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (maddr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign rd_valid = rvalid_q && valid_q[ridx_q];
  assign rd_match = rd_valid && rdata.host == req_q.host_key && rdata.port == req_q.port;
  assign rd_exp   = rdata.expiry != '0 && {1'b0, req_q.now_ms} >= rdata.expiry;
  assign hit_exp  = hit_ent_q.expiry != '0 && {1'b0, req_q.now_ms} >= hit_ent_q.expiry;
  assign new_exp  = (life_q == '0) ? '0 : {1'b0, req_q.now_ms} + {17'd0, life_q};

  logic do_store;
  logic [IdxW-1:0] store_idx;
  always_comb begin
    do_store  = 1'b0;
    store_idx = hit_q ? hit_idx_q : free_idx_q;
    case (req_q.op)
      OP_VERIFY: do_store = !hit_q ? free_q : hit_exp;
      OP_PIN:    do_store = hit_q || free_q;
      default:   do_store = 1'b0;
    endcase
  end

  always_comb begin
    wdata.host       = req_q.host_key;
    wdata.port       = req_q.port;
    wdata.fp         = req_q.fp_digest;
    wdata.first_seen = req_q.now_ms;
    wdata.expiry     = new_exp;
    we    = (state_q == S_WRITE) && do_store;
    maddr = (state_q == S_WRITE) ? store_idx : addr_q[IdxW-1:0];
  end

  always_comb begin
    rsp_d            = '0;
    rsp_d.status     = ST_OK;
    rsp_d.live_count = used_q;
    case (req_q.op)
      OP_VERIFY: rsp_d.status = !hit_q ? ST_NEW : hit_exp ? ST_EXPIRED :
                                (hit_ent_q.fp == req_q.fp_digest) ? ST_MATCH
                                                                  : ST_MISMATCH;
      OP_PIN:    rsp_d.status = (hit_q || free_q) ? ST_OK : ST_FULL;
      OP_REVOKE: rsp_d.status = hit_q ? ST_OK : ST_NOTFOUND;
      OP_PRUNE:  rsp_d.pruned_count = pruned_q;
      OP_LOOKUP: begin
        rsp_d.status = hit_q ? ST_OK : ST_NOTFOUND;
        if (hit_q) begin
          rsp_d.found_fp         = hit_ent_q.fp;
          rsp_d.found_first_seen = hit_ent_q.first_seen;
          rsp_d.found_expiry     = hit_ent_q.expiry;
        end
      end
      default: rsp_d.status = ST_OK;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start && !busy) state_d = S_SCAN;
      S_SCAN:  if (!rvalid_q && addr_q[IdxW]) state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      life_q   <= '0;
      valid_q  <= '0;
      used_q   <= '0;
      addr_q   <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) life_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          addr_q   <= '0;
          rvalid_q <= 1'b0;
        end
        S_SCAN: begin
          rvalid_q <= !addr_q[IdxW];
          if (!addr_q[IdxW]) addr_q <= addr_q + 1'b1;
          if (req_q.op == OP_PRUNE && rd_valid && rd_exp) begin
            valid_q[ridx_q] <= 1'b0;
            if (used_q != '0) used_q <= used_q - 1'b1;
          end
        end
        S_WRITE: begin
          if (req_q.op == OP_REVOKE && hit_q) begin
            valid_q[hit_idx_q] <= 1'b0;
            if (used_q != '0) used_q <= used_q - 1'b1;
          end else if (do_store && !hit_q) begin
            valid_q[free_idx_q] <= 1'b1;
            used_q <= used_q + 1'b1;
          end
        end
        S_DONE: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= addr_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start && !busy) req_q <= req_i;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
        pruned_q <= '0;
      end
      S_SCAN: begin
        if (rd_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ridx_q;
          hit_ent_q <= rdata;
        end
        if (rvalid_q && !valid_q[ridx_q] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= ridx_q;
        end
        if (req_q.op == OP_PRUNE && rd_valid && rd_exp) pruned_q <= pruned_q + 1'b1;
      end
      S_DONE: rsp_q <= rsp_d;
      default: ;
    endcase
  end

  assign busy   = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_RST(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "done longer than a cycle")
  `ASSERT_RST(a_busy_done, clk_i, rst_ni, done_q |-> busy, "done while not busy")
  `ASSERT_RST(a_we_write, clk_i, rst_ni, we |-> state_q == S_WRITE, "write outside write state")
  `ASSERT_RST(a_used_max, clk_i, rst_ni, used_q <= CntW'(TableEntries), "used count overflow")
endmodule
`default_nettype wire

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the pin table with expiry: a queue-fed driver
// issues verify, pin, revoke, prune, lookup and bad-op words over several
// lifetime settings; a monitor compares each response with a table model
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
  import fupt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [2:0] OpBad5 = 3'd5;
  localparam logic [2:0] OpBad7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  first_use_pin_table_with_expiry u_top (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // table model
  logic        pin_valid [TableEntries];
  entry_t      pin_entry [TableEntries];
  int unsigned pin_used;
  logic [31:0] lifetime_ms;

  req_t req_queue [$];
  rsp_t rsp_queue [$];
  int   gap_left = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   phase_done = 1'b0;
  bit   timed_out = 1'b0;

  function automatic int find_pin(logic [63:0] host, logic [15:0] port);
    for (int i = 0; i < TableEntries; i++)
      if (pin_valid[i] && pin_entry[i].host == host && pin_entry[i].port == port) return i;
    return -1;
  endfunction

  function automatic bit pin_expired(int i, logic [47:0] now);
    return pin_entry[i].expiry != '0 && {1'b0, now} >= pin_entry[i].expiry;
  endfunction

  function automatic bit store_pin(req_t r);
    int i;
    i = find_pin(r.host_key, r.port);
    if (i < 0) begin
      for (int k = 0; k < TableEntries; k++)
        if (!pin_valid[k]) begin
          i = k;
          break;
        end
      if (i < 0) return 1'b0;
      pin_valid[i] = 1'b1;
      pin_used++;
    end
    pin_entry[i].host = r.host_key;
    pin_entry[i].port = r.port;
    pin_entry[i].fp = r.fp_digest;
    pin_entry[i].first_seen = r.now_ms;
    pin_entry[i].expiry = (lifetime_ms == 0) ? '0 : {1'b0, r.now_ms} + {17'd0, lifetime_ms};
    return 1'b1;
  endfunction

  function automatic rsp_t apply_word(req_t r);
    rsp_t o;
    int   i;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_VERIFY: begin
        i = find_pin(r.host_key, r.port);
        if (i < 0) begin
          void'(store_pin(r));
          o.status = ST_NEW;
        end else if (pin_expired(i, r.now_ms)) begin
          void'(store_pin(r));
          o.status = ST_EXPIRED;
        end else begin
          o.status = (pin_entry[i].fp == r.fp_digest) ? ST_MATCH : ST_MISMATCH;
        end
      end
      OP_PIN: o.status = store_pin(r) ? ST_OK : ST_FULL;
      OP_REVOKE: begin
        i = find_pin(r.host_key, r.port);
        if (i < 0) o.status = ST_NOTFOUND;
        else begin
          pin_valid[i] = 1'b0;
          pin_used--;
        end
      end
      OP_PRUNE: begin
        for (int k = 0; k < TableEntries; k++)
          if (pin_valid[k] && pin_expired(k, r.now_ms)) begin
            pin_valid[k] = 1'b0;
            pin_used--;
            o.pruned_count++;
          end
      end
      OP_LOOKUP: begin
        i = find_pin(r.host_key, r.port);
        if (i < 0) o.status = ST_NOTFOUND;
        else begin
          o.found_fp = pin_entry[i].fp;
          o.found_first_seen = pin_entry[i].first_seen;
          o.found_expiry = pin_entry[i].expiry;
        end
      end
      default: ;
    endcase
    o.live_count = pin_used[8:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        rsp_queue.push_back(apply_word(req_i));
        void'(req_queue.pop_front());
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if ((start && !busy ? req_queue.size() > 1 : req_queue.size() > 0)) begin
        req_i <= (start && !busy) ? req_queue[1] : req_queue[0];
        start <= 1'b1;
        if (start && !busy && $urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 5);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (rsp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", rsp_o);
        end else begin
          want = rsp_queue.pop_front();
          if (rsp_o.status !== want.status || rsp_o.pruned_count !== want.pruned_count ||
              rsp_o.live_count !== want.live_count || rsp_o.found_fp !== want.found_fp ||
              rsp_o.found_first_seen !== want.found_first_seen ||
              rsp_o.found_expiry !== want.found_expiry) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: exp %h got %h", want, rsp_o);
          end
        end
      end
      if (done_o || (start && !busy) || (req_queue.size() == 0 && rsp_queue.size() == 0))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("** first_use_pin_table_with_expiry: FAILED **");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_word(logic [2:0] op, logic [63:0] host, logic [15:0] port,
                                     logic [63:0] fp, logic [47:0] now);
    req_t r;
    r.op = op;
    r.host_key = host;
    r.port = port;
    r.fp_digest = fp;
    r.now_ms = now;
    return r;
  endfunction

  task automatic drain();
    wait (req_queue.size() == 0 && !start);
    wait (rsp_queue.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_lifetime(logic [31:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lifetime_ms = v;
  endtask

  task automatic random_phase(int n);
    logic [63:0] hosts [8];
    logic [15:0] ports [8];
    logic [47:0] now;
    int          k;
    logic [2:0]  op;
    for (int i = 0; i < 8; i++) begin
      hosts[i] = {$urandom, $urandom};
      ports[i] = 16'($urandom);
    end
    now = {16'd0, $urandom};
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 7);
      now = now + 48'($urandom_range(0, 2000));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = OP_VERIFY;
        6, 7, 8, 9: op = OP_PIN;
        10, 11: op = OP_REVOKE;
        12: op = OP_PRUNE;
        13, 14, 15, 16, 17: op = OP_LOOKUP;
        default: op = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 9) == 0)
        req_queue.push_back(make_word(op, {$urandom, $urandom}, 16'($urandom),
                                      {$urandom, $urandom}, 48'({$urandom, $urandom})));
      else
        req_queue.push_back(make_word(op, hosts[k], ports[k],
                                      ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                                  : {hosts[k][31:0], 32'h5a5a},
                                      now));
    end
  endtask

  initial begin
    for (int i = 0; i < TableEntries; i++) pin_valid[i] = 1'b0;
    pin_used = 0;
    lifetime_ms = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: never-expiring pins, field extremes, all ops
    req_queue.push_back(make_word(OP_LOOKUP, '1, '1, '1, '1));
    req_queue.push_back(make_word(OP_VERIFY, '1, '1, '1, '1));
    req_queue.push_back(make_word(OP_VERIFY, '1, '1, '1, 48'd5));
    req_queue.push_back(make_word(OP_VERIFY, '1, '1, '0, 48'd5));
    req_queue.push_back(make_word(OP_VERIFY, '0, '0, '0, '0));
    req_queue.push_back(make_word(OP_LOOKUP, '1, '1, '0, '0));
    req_queue.push_back(make_word(OP_PIN, '0, '0, '1, 48'd9));
    req_queue.push_back(make_word(OP_REVOKE, '0, 16'd1, '0, '0));
    req_queue.push_back(make_word(OP_REVOKE, '0, '0, '0, '0));
    req_queue.push_back(make_word(OP_PRUNE, '0, '0, '0, '1));
    req_queue.push_back(make_word(OpBad5, '1, '1, '1, '1));
    req_queue.push_back(make_word(OpBad7, '1, '1, '1, '1));
    drain();

    // short lifetime: expiry, re-pin and prune
    set_lifetime(32'd10);
    req_queue.push_back(make_word(OP_VERIFY, 64'h1, 16'd22, 64'hab, 48'd100));
    req_queue.push_back(make_word(OP_VERIFY, 64'h1, 16'd22, 64'hab, 48'd109));
    req_queue.push_back(make_word(OP_LOOKUP, 64'h1, 16'd22, '0, 48'd109));
    req_queue.push_back(make_word(OP_VERIFY, 64'h1, 16'd22, 64'hcd, 48'd110));
    req_queue.push_back(make_word(OP_PIN, 64'h2, 16'd22, 64'hcd, 48'd110));
    req_queue.push_back(make_word(OP_PRUNE, '0, '0, '0, 48'd120));
    drain();

    // largest lifetime at the top of time: expiry carries into bit 48
    set_lifetime('1);
    req_queue.push_back(make_word(OP_PIN, 64'h3, 16'd443, 64'h77, '1));
    req_queue.push_back(make_word(OP_LOOKUP, 64'h3, 16'd443, '0, '1));
    req_queue.push_back(make_word(OP_PRUNE, '0, '0, '0, '1));
    drain();

    // fill the table, then full pin and full verify
    set_lifetime(32'd0);
    for (int i = 0; i < TableEntries + 1; i++)
      req_queue.push_back(make_word(OP_PIN, 64'hf000 + 64'(i), 16'd80, 64'(i), 48'd1));
    req_queue.push_back(make_word(OP_VERIFY, 64'hdead, 16'd1, '0, 48'd2));
    req_queue.push_back(make_word(OP_LOOKUP, 64'hdead, 16'd1, '0, 48'd2));
    for (int i = 0; i < TableEntries; i++)
      req_queue.push_back(make_word(OP_REVOKE, 64'hf000 + 64'(i), 16'd80, '0, 48'd3));
    drain();

    set_lifetime(32'd3000);
    random_phase(250);
    set_lifetime(32'd500);
    random_phase(250);
    set_lifetime(32'd0);
    random_phase(150);
    set_lifetime(32'hffff_fff0);
    random_phase(150);
    drain();
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && rsp_queue.size() == 0)
      $display("** first_use_pin_table_with_expiry: PASSED **");
    else
      $display("** first_use_pin_table_with_expiry: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
